// ===== design/micd_pkg.sv =====
// micd_pkg: shared types and constants of the multi-input change debouncer
// used by the lane, the report scanner and the top level
package micd_pkg;

	localparam int unsigned DIGITAL_BITS = 14;
	localparam int unsigned SAMPLE_W     = 10;
	localparam int unsigned FILTER_W     = 5;
	localparam int unsigned COUNT_W      = 6;
	localparam int unsigned CHAN_W       = 4;
	localparam int unsigned CFG_DATA_W   = 10;

	localparam logic [FILTER_W-1:0] FILTER_RESET    = 5'd16;
	localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd500;
	localparam logic [COUNT_W-1:0]  COUNT_MAX       = 6'd63;

	typedef enum logic {
		CFG_FILTER_COUNT     = 1'b0,
		CFG_ANALOG_THRESHOLD = 1'b1
	} cfg_index_t;

	// what one lane decided for its channel on this tick
	typedef struct packed {
		logic report;
		logic level;
	} lane_res_t;

endpackage

// ===== design/micd_lane.sv =====
// micd_lane: debounce logic of one channel, next count and reported level
// depends on micd_pkg
module micd_lane import micd_pkg::*; (
	input  logic                level,
	input  logic                reported,
	input  logic [COUNT_W-1:0]  count,
	input  logic [FILTER_W-1:0] filter_count,
	input  logic                report_all,
	output logic                next_reported,
	output logic [COUNT_W-1:0]  next_count,
	output lane_res_t           res
);

	always_comb begin
		next_reported = reported;
		next_count    = '0;
		res.level     = level;
		res.report    = 1'b0;
		if (report_all) begin
			res.report    = 1'b1;
			next_reported = level;
		end else if (level == reported) begin
			next_count = '0;
		end else if (count < COUNT_W'(filter_count)) begin
			next_count = (count < COUNT_MAX) ? count + 1'b1 : count;
		end else begin
			res.report    = 1'b1;
			next_reported = level;
		end
	end

endmodule

// ===== design/micd_emit.sv =====
// micd_emit: walks the report mask of one tick in channel order and sends
// one report per transfer through an output register; depends on micd_pkg
module micd_emit import micd_pkg::*; #(
	parameter int unsigned CHANNELS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [CHANNELS-1:0] mask,
	input  logic [CHANNELS-1:0] levels,
	output logic                busy,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [7:0]          m_axis_tdata,
	output logic                m_axis_tlast
);

	localparam int unsigned IW = $clog2(CHANNELS);

	logic                busy_q;
	logic [IW-1:0]       idx_q;
	logic [CHANNELS-1:0] mask_q;
	logic [CHANNELS-1:0] lvl_q;
	logic                out_valid_q;
	logic [CHAN_W-1:0]   out_chan_q;
	logic                out_lvl_q;
	logic                out_last_q;

	logic [CHANNELS-1:0] sel;
	logic [CHANNELS-1:0] rest;
	logic                hit;
	logic                out_free;
	logic                load;

	always_comb begin
		sel        = '0;
		sel[idx_q] = 1'b1;
		rest       = mask_q & ~sel;
		hit        = mask_q[idx_q];
		out_free   = !out_valid_q || m_axis_tready;
		load       = busy_q && hit && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= |mask;
				idx_q  <= '0;
			end else if (busy_q) begin
				if (!hit || out_free)
					idx_q <= idx_q + 1'b1;
				// done once the last pending report has gone to the output register
				if (load && rest == '0)
					busy_q <= 1'b0;
			end
			if (load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mask_q <= mask;
			lvl_q  <= levels;
		end else if (load) begin
			mask_q <= rest;
		end
		if (load) begin
			out_chan_q <= CHAN_W'(idx_q);
			out_lvl_q  <= lvl_q[idx_q];
			out_last_q <= (rest == '0);
		end
	end

	assign busy          = busy_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_lvl_q, out_chan_q};
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== design/multi_input_change_debouncer_top.sv =====
// multi_input_change_debouncer_top: per-channel debounce lanes, register port
// and report scanner; depends on micd_pkg, micd_lane and micd_emit
//
// Each input transfer is one poll tick. All channels are updated in parallel
// lanes in the cycle the tick is taken, then the scanner visits the channels
// one per cycle, holding on a report while the output register is full, and
// sends each report as its own output transfer, the final one of the tick
// with tlast set. The scan stops once the last report of the tick is loaded,
// and a tick with no reports does not start it; s_axis_tready is low while
// the scanner runs. A finished report waits in the output register without
// holding up the next tick. Configuration writes are taken in any cycle and
// should be issued only while the block is idle.
module multi_input_change_debouncer_top import micd_pkg::*; #(
	parameter int unsigned CHANNELS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [13:0] digital_levels, [23:14] analog_sample_a, [33:24] analog_sample_b
	input  logic [39:0]           s_axis_tdata,
	// [0] report_all
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [3:0] channel, [4] level
	output logic [7:0]            m_axis_tdata,
	output logic                  m_axis_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [FILTER_W-1:0] filter_q;
	logic [SAMPLE_W-1:0] threshold_q;
	logic [CHANNELS-1:0] reported_q;
	logic [COUNT_W-1:0]  count_q [CHANNELS];

	logic [CHANNELS-1:0] sampled;
	logic [CHANNELS-1:0] next_reported;
	logic [COUNT_W-1:0]  next_count [CHANNELS];
	lane_res_t           res [CHANNELS];
	logic [CHANNELS-1:0] rep_mask;
	logic [CHANNELS-1:0] rep_levels;
	logic                level_a;
	logic                level_b;
	logic                accept;
	logic                busy;

	assign level_a   = s_axis_tdata[23:14] >= threshold_q;
	assign level_b   = s_axis_tdata[33:24] >= threshold_q;
	assign s_axis_tready = !busy;
	assign accept    = s_axis_tvalid && !busy;
	assign cfg_ready = 1'b1;

	for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
		if (ch == CHANNELS - 2) begin : g_a
			assign sampled[ch] = level_a;
		end else if (ch == CHANNELS - 1) begin : g_b
			assign sampled[ch] = level_b;
		end else if (ch < DIGITAL_BITS) begin : g_dig
			assign sampled[ch] = s_axis_tdata[ch];
		end else begin : g_none
			assign sampled[ch] = 1'b0;
		end

		micd_lane u_lane (
			.level         (sampled[ch]),
			.reported      (reported_q[ch]),
			.count         (count_q[ch]),
			.filter_count  (filter_q),
			.report_all    (s_axis_tuser),
			.next_reported (next_reported[ch]),
			.next_count    (next_count[ch]),
			.res           (res[ch])
		);

		assign rep_mask[ch]   = res[ch].report;
		assign rep_levels[ch] = res[ch].level;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				count_q[ch] <= '0;
			end else if (accept) begin
				count_q[ch] <= next_count[ch];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reported_q  <= '0;
			filter_q    <= FILTER_RESET;
			threshold_q <= THRESHOLD_RESET;
		end else begin
			if (accept)
				reported_q <= next_reported;
			if (cfg_valid) begin
				unique case (cfg_index_t'(cfg_index))
					CFG_FILTER_COUNT:     filter_q    <= cfg_data[FILTER_W-1:0];
					CFG_ANALOG_THRESHOLD: threshold_q <= cfg_data[SAMPLE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	micd_emit #(
		.CHANNELS (CHANNELS)
	) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (accept),
		.mask          (rep_mask),
		.levels        (rep_levels),
		.busy          (busy),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== design/micd_checker.sv =====
// micd_checker: port-level checks of the debouncer top level, with its bind
// depends on micd_pkg and multi_input_change_debouncer_top
module micd_checker import micd_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [39:0]           s_axis_tdata,
	input logic                  s_axis_tuser,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [7:0]            m_axis_tdata,
	input logic                  m_axis_tlast,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic                  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	// a stalled report holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled report changed");

	// padding bits of a report stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:5] == 3'b000)
		else $error("report padding not zero");

	// while a tick still has reports to send, no new tick is taken
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("tick taken before previous tick finished");

	// the register port never back-pressures
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write stalled");

endmodule

bind multi_input_change_debouncer_top micd_checker u_micd_checker (.*);
